>>> hdl/tslc_pkg.sv
// ----------------------------------------------------------------------------
// Tile sprite layer compositor package
// Shared constants, item kinds, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package tslc_pkg;

  localparam int FRAME_WIDTH_DEF      = 320;
  localparam int FRAME_HEIGHT_DEF     = 224;
  localparam int TILE_STORE_BYTES_DEF = 131072;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 10;
  localparam int TILES_W  = 3;
  localparam int FIRST_W  = 11;
  localparam int PAL_W    = 4;
  localparam int ADDR_W   = 17;
  localparam int PIX_W    = 8;
  localparam int CW_W     = 9;
  localparam int VOFF_W   = 9;
  localparam int TBL_W    = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam int OFF_W    = 18;

  localparam logic [CW_W-1:0] CW_RESET = 9'd320;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_BYTES      = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 3'd0,
    KIND_TILE    = 3'd1,
    KIND_STATIC  = 3'd2,
    KIND_DYNAMIC = 3'd3,
    KIND_MERGE   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_TW,
    ST_MRD,
    ST_MRES,
    ST_SADDR,
    ST_SRD,
    ST_SWR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_run;
    logic calc;
    logic step;
    logic spr_we;
    logic tile_we;
    logic merge_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic last;
  } sts_t;

endpackage

>>> hdl/tslc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tslc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/tslc_ctrl.sv
// ----------------------------------------------------------------------------
// Compositor controller
// Sequences clear sweeps, tile writes, merges and the per-pixel sprite walk.
// ----------------------------------------------------------------------------
module tslc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tslc_pkg::KIND_W-1:0] kind_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tslc_pkg::cmd_t              cmd_o,
  input  tslc_pkg::sts_t              sts_i
);
  import tslc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (kind_e'(kind_i))
            KIND_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d = ST_CLR;
            end
            KIND_TILE:    state_d = ST_TW;
            KIND_STATIC:  state_d = ST_SADDR;
            KIND_DYNAMIC: state_d = ST_SADDR;
            KIND_MERGE:   state_d = ST_MRD;
            default:      state_d = ST_FIN;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_FIN;
        end
      end
      ST_TW: begin
        cmd_o.tile_we = 1'b1;
        state_d = ST_FIN;
      end
      ST_MRD: begin
        state_d = ST_MRES;
      end
      ST_MRES: begin
        cmd_o.merge_done = 1'b1;
        state_d = ST_FIN;
      end
      ST_SADDR: begin
        if (sts_i.empty) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.calc = 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        state_d = ST_SWR;
      end
      ST_SWR: begin
        cmd_o.spr_we = 1'b1;
        cmd_o.step   = 1'b1;
        state_d = sts_i.last ? ST_FIN : ST_SADDR;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/tslc_dp.sv
// ----------------------------------------------------------------------------
// Compositor datapath
// Item and configuration registers, sprite address math, layer and tile RAMs.
// ----------------------------------------------------------------------------
module tslc_dp #(
  parameter int FRAME_WIDTH      = tslc_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT     = tslc_pkg::FRAME_HEIGHT_DEF,
  parameter int TILE_STORE_BYTES = tslc_pkg::TILE_STORE_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tslc_pkg::cmd_t                  cmd_i,
  output tslc_pkg::sts_t                  sts_o,
  input  logic                            cfg_we_i,
  input  logic [tslc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tslc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [tslc_pkg::KIND_W-1:0]     kind_i,
  input  logic signed [tslc_pkg::POS_W-1:0] x_i,
  input  logic signed [tslc_pkg::POS_W-1:0] y_i,
  input  logic [tslc_pkg::TILES_W-1:0]    width_tiles_i,
  input  logic [tslc_pkg::TILES_W-1:0]    height_tiles_i,
  input  logic [tslc_pkg::FIRST_W-1:0]    first_tile_i,
  input  logic [tslc_pkg::PAL_W-1:0]      palette_i,
  input  logic                            flip_h_i,
  input  logic                            flip_v_i,
  input  logic                            high_priority_i,
  input  logic [tslc_pkg::ADDR_W-1:0]     address_i,
  input  logic [tslc_pkg::PIX_W-1:0]      value_i,
  output logic [tslc_pkg::PIX_W-1:0]      pixel_o,
  output logic                            from_layer_o
);
  import tslc_pkg::*;

  localparam int LAYER_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int LAW = $clog2(LAYER_DEPTH);
  localparam int TAW = $clog2(TILE_STORE_BYTES);

  logic [CW_W-1:0]          cw_q;
  logic signed [VOFF_W-1:0] voff_q;
  logic [TBL_W-1:0]         tbl_q;

  logic [KIND_W-1:0]        kind_q;
  logic signed [POS_W-1:0]  x_q, y_q;
  logic [TILES_W-1:0]       wt_q, ht_q;
  logic [FIRST_W-1:0]       first_q;
  logic [PAL_W-1:0]         pal_q;
  logic                     fh_q, fv_q, prio_q;
  logic [ADDR_W-1:0]        addr_q;
  logic [PIX_W-1:0]         val_q;

  logic [4:0]     px_q, py_q;
  logic [LAW-1:0] clr_cnt_q;
  logic [LAW-1:0] pos_q;
  logic [OFF_W-1:0] off_q;
  logic           ok_q;
  logic [PIX_W-1:0] res_pix_q;
  logic           res_hit_q;

  logic [TILES_W-1:0] wtc, htc;
  logic [5:0]     wfull, hfull;
  logic [4:0]     wm1, hm1;
  logic [1:0]     tx, ty_t, tcol, trow;
  logic [2:0]     ix, iy;
  logic [4:0]     tprod;
  logic [11:0]    tile;
  logic [OFF_W-1:0] off;
  logic           off_ok;

  logic signed [12:0] ys, ty, lx;
  logic signed [31:0] diff, left, col, pos;
  logic           ty_ok, lx_ok, col_ok;

  logic [31:0]    maddr;
  logic           maddr_ok;
  logic [LAW-1:0] lay_raddr, lay_waddr;
  logic [PIX_W:0] lay_wdata, lay_rdata;
  logic           lay_we;
  logic [PIX_W-1:0] tile_rdata, colour;
  logic           tile_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q   <= CW_RESET;
      voff_q <= '0;
      tbl_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CONTENT_WIDTH:   cw_q   <= cfg_data_i[CW_W-1:0];
        CFG_VERTICAL_OFFSET: voff_q <= $signed(cfg_data_i[VOFF_W-1:0]);
        CFG_TILE_BYTES:      tbl_q  <= cfg_data_i[TBL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      x_q     <= x_i;
      y_q     <= y_i;
      wt_q    <= width_tiles_i;
      ht_q    <= height_tiles_i;
      first_q <= first_tile_i;
      pal_q   <= palette_i;
      fh_q    <= flip_h_i;
      fv_q    <= flip_v_i;
      prio_q  <= high_priority_i;
      addr_q  <= address_i;
      val_q   <= value_i;
    end
    if (cmd_i.calc) begin
      pos_q <= pos[LAW-1:0];
      off_q <= off;
      ok_q  <= ty_ok && lx_ok && col_ok && off_ok;
    end
    if (cmd_i.load) begin
      res_pix_q <= '0;
      res_hit_q <= 1'b0;
    end else if (cmd_i.merge_done) begin
      res_hit_q <= maddr_ok && (lay_rdata[PIX_W-1:0] != '0) && (lay_rdata[PIX_W] == prio_q);
      res_pix_q <= (maddr_ok && (lay_rdata[PIX_W-1:0] != '0) && (lay_rdata[PIX_W] == prio_q))
                   ? lay_rdata[PIX_W-1:0] : val_q;
    end
    if (cmd_i.out_load) begin
      pixel_o      <= res_pix_q;
      from_layer_o <= res_hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q      <= '0;
      py_q      <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        px_q <= '0;
        py_q <= '0;
      end else if (cmd_i.step) begin
        if (px_q == wm1) begin
          px_q <= '0;
          py_q <= py_q + 5'd1;
        end else begin
          px_q <= px_q + 5'd1;
        end
      end
      if (cmd_i.clr_start || (cmd_i.clr_run && sts_o.clr_last)) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_run) begin
        clr_cnt_q <= clr_cnt_q + LAW'(1);
      end
    end
  end

  // Sprite size, clamped to four tiles a side
  assign wtc   = (wt_q > 3'd4) ? 3'd4 : wt_q;
  assign htc   = (ht_q > 3'd4) ? 3'd4 : ht_q;
  assign wfull = {wtc, 3'b000} - 6'd1;
  assign hfull = {htc, 3'b000} - 6'd1;
  assign wm1   = wfull[4:0];
  assign hm1   = hfull[4:0];

  assign sts_o.empty    = (wtc == '0) || (htc == '0);
  assign sts_o.last     = (px_q == wm1) && (py_q == hm1);
  assign sts_o.clr_last = (clr_cnt_q == LAW'(LAYER_DEPTH - 1));

  // Source texel with mirroring, tiles in column-major order
  assign tx    = px_q[4:3];
  assign ty_t  = py_q[4:3];
  assign tcol  = fh_q ? 2'(wtc - 3'd1 - {1'b0, tx}) : tx;
  assign trow  = fv_q ? 2'(htc - 3'd1 - {1'b0, ty_t}) : ty_t;
  assign ix    = fh_q ? ~px_q[2:0] : px_q[2:0];
  assign iy    = fv_q ? ~py_q[2:0] : py_q[2:0];
  assign tprod = 5'(tcol * htc);
  assign tile  = 12'(first_q) + 12'(tprod) + 12'(trow);
  assign off   = {tile, iy, ix};
  assign off_ok = (off < tbl_q) && (32'(off) < 32'(TILE_STORE_BYTES));

  // Frame placement
  assign ys   = (kind_e'(kind_q) == KIND_STATIC) ? 13'(voff_q) : 13'sd0;
  assign ty   = 13'(y_q) + ys + $signed({8'd0, py_q});
  assign lx   = 13'(x_q) + $signed({8'd0, px_q});
  assign diff = 32'(FRAME_WIDTH) - $signed({23'd0, cw_q});
  assign left = $signed(diff + $signed({31'd0, diff[31]})) >>> 1;
  assign col  = left + 32'(lx);
  assign ty_ok  = !ty[12] && (32'(ty) < 32'(FRAME_HEIGHT));
  assign lx_ok  = !lx[12] && (32'(lx) < 32'(cw_q));
  assign col_ok = !col[31] && (col < 32'(FRAME_WIDTH));
  assign pos    = 32'(ty) * 32'(FRAME_WIDTH) + col;

  // Merge address
  assign maddr    = 32'(addr_q);
  assign maddr_ok = maddr < 32'(LAYER_DEPTH);

  assign colour    = tile_rdata;
  assign lay_raddr = (kind_e'(kind_q) == KIND_MERGE) ? maddr[LAW-1:0] : pos_q;
  assign lay_we    = cmd_i.clr_run ||
                     (cmd_i.spr_we && ok_q && (lay_rdata[PIX_W-1:0] == '0) && (colour != '0));
  assign lay_waddr = cmd_i.clr_run ? clr_cnt_q : pos_q;
  assign lay_wdata = cmd_i.clr_run ? '0 : {prio_q, 8'({pal_q, 4'b0000} + colour)};
  assign tile_we   = cmd_i.tile_we && (32'(addr_q) < 32'(TILE_STORE_BYTES));

  tslc_ram #(
    .WIDTH (PIX_W + 1),
    .DEPTH (LAYER_DEPTH)
  ) u_layer (
    .clk_i   (clk_i),
    .we_i    (lay_we),
    .waddr_i (lay_waddr),
    .wdata_i (lay_wdata),
    .raddr_i (lay_raddr),
    .rdata_o (lay_rdata)
  );

  tslc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TILE_STORE_BYTES)
  ) u_tiles (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (maddr[TAW-1:0]),
    .wdata_i (val_q),
    .raddr_i (off_q[TAW-1:0]),
    .rdata_o (tile_rdata)
  );

endmodule

>>> hdl/tile_sprite_layer_compositor.sv
// ----------------------------------------------------------------------------
// Tile sprite layer compositor
// Draws tiled sprites into a layer store and merges the layer into frame pixels.
//
//   channel | signals                              | direction
//   in      | in_valid_i, in_stall_o, item fields  | to block
//   out     | out_valid_o, out_stall_i, pixel_o,   | from block
//           | from_layer_o                         |
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i    | to block
//
// Unused kinds go straight to the finish state, a tile write passes ST_TW,
// a merge ST_MRD and ST_MRES, and each sprite pixel (up to 32 x 32) passes
// ST_SADDR, ST_SRD and ST_SWR for the read-then-write on the layer RAM.
// Clear sweeps all FRAME_WIDTH*FRAME_HEIGHT layer entries, one a cycle.
// After reset the same sweep runs with in stalled. A result waits in the
// output register; out stall holds the block before it returns to idle.
// ----------------------------------------------------------------------------
module tile_sprite_layer_compositor #(
  parameter int FRAME_WIDTH      = tslc_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT     = tslc_pkg::FRAME_HEIGHT_DEF,
  parameter int TILE_STORE_BYTES = tslc_pkg::TILE_STORE_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tslc_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [tslc_pkg::POS_W-1:0] x_i,
  input  logic signed [tslc_pkg::POS_W-1:0] y_i,
  input  logic [tslc_pkg::TILES_W-1:0]      width_tiles_i,
  input  logic [tslc_pkg::TILES_W-1:0]      height_tiles_i,
  input  logic [tslc_pkg::FIRST_W-1:0]      first_tile_i,
  input  logic [tslc_pkg::PAL_W-1:0]        palette_i,
  input  logic                              flip_h_i,
  input  logic                              flip_v_i,
  input  logic                              high_priority_i,
  input  logic [tslc_pkg::ADDR_W-1:0]       address_i,
  input  logic [tslc_pkg::PIX_W-1:0]        value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tslc_pkg::PIX_W-1:0]        pixel_o,
  output logic                              from_layer_o,
  input  logic                              cfg_we_i,
  input  logic [tslc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tslc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tslc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tslc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tslc_dp #(
    .FRAME_WIDTH      (FRAME_WIDTH),
    .FRAME_HEIGHT     (FRAME_HEIGHT),
    .TILE_STORE_BYTES (TILE_STORE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .x_i             (x_i),
    .y_i             (y_i),
    .width_tiles_i   (width_tiles_i),
    .height_tiles_i  (height_tiles_i),
    .first_tile_i    (first_tile_i),
    .palette_i       (palette_i),
    .flip_h_i        (flip_h_i),
    .flip_v_i        (flip_v_i),
    .high_priority_i (high_priority_i),
    .address_i       (address_i),
    .value_i         (value_i),
    .pixel_o         (pixel_o),
    .from_layer_o    (from_layer_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting an item");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in flight");

  a_layer_pixel_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_layer_o |-> pixel_o != '0)
    else $error("layer hit with zero pixel");
`endif

endmodule
